### hw/rtl/nfasim_pkg.sv
// ----------------------------------------------------------------------------
// nfasim_pkg
// Shared types and constants of the epsilon-NFA simulator.
// ----------------------------------------------------------------------------
package nfasim_pkg;

  localparam int NumStates  = 16;
  localparam int NumSymbols = 16;
  localparam int StateW     = 4;
  localparam int SymW       = 4;
  localparam int SetW       = NumStates;
  localparam int TransDepth = NumStates * NumSymbols;
  localparam int TransAw    = SymW + StateW;
  localparam int CntW       = StateW + 1;

  typedef enum logic [1:0] {
    REQ_TRANS  = 2'd0,
    REQ_EPS    = 2'd1,
    REQ_SYMBOL = 2'd2,
    REQ_FINISH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    VERDICT_REJECT  = 2'd0,
    VERDICT_ACCEPT  = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    CFG_START_STATE   = 2'd0,
    CFG_FINAL_MASK    = 2'd1,
    CFG_ALPHABET_MASK = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_STEP,
    ST_EMIT
  } fsm_e;

  typedef struct packed {
    logic               trans_we;
    logic               eps_we;
    logic [TransAw-1:0] trans_waddr;
    logic [StateW-1:0]  eps_waddr;
    logic [SetW-1:0]    wdata;
    logic [TransAw-1:0] trans_raddr;
    logic [StateW-1:0]  eps_raddr;
  } tbl_ctrl_t;

endpackage

### hw/rtl/nfa_epsilon_simulator.sv
// ----------------------------------------------------------------------------
// nfa_epsilon_simulator
// Epsilon-NFA simulator over a 16-state active set.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A row write is done in the cycle that
// takes it. A symbol item runs the epsilon closure as repeated passes over
// the epsilon memory, one row read per cycle, until a pass adds nothing (1
// to 16 passes), then one pass over the symbol's rows of the transition
// memory; no new item is taken until the block is back in idle. A finish
// item runs the closure, unless the word is invalid, and then loads the
// result register, which can hold a finished result while the next item is
// taken; a waiting result stalls the next finish item in that load state.
// Each table memory has a single read port, so each pass reads its rows one
// at a time. Tables reset to empty through valid bits, so no clearing pass
// is needed. A symbol item that is invalid, or any symbol after it in the
// same word, is dropped without leaving idle.
module nfa_epsilon_simulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  symbol_i,
  input  logic [3:0]  state_index_i,
  input  logic [15:0] row_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [15:0] final_set_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import nfasim_pkg::*;

  fsm_e              state_q, state_d;
  logic [StateW-1:0] start_q, start_d;
  logic [SetW-1:0]   final_q, final_d;
  logic [SetW-1:0]   alpha_q, alpha_d;
  logic [SetW-1:0]   active_q, active_d;
  logic [SetW-1:0]   acc_q, acc_d;
  logic              invalid_q, invalid_d;
  logic              fin_q, fin_d;
  logic              chg_q, chg_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [StateW-1:0] rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        verdict_q, verdict_d;
  logic [SetW-1:0]   fset_q, fset_d;

  tbl_ctrl_t         tbl_ctrl;
  logic [SetW-1:0]   trans_rdata;
  logic [SetW-1:0]   eps_rdata;
  logic              in_acc;
  logic              cfg_acc;

  nfasim_tables u_tables (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tbl_ctrl),
    .trans_rdata_o(trans_rdata),
    .eps_rdata_o  (eps_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    final_d     = final_q;
    alpha_d     = alpha_q;
    active_d    = active_q;
    acc_d       = acc_q;
    invalid_d   = invalid_q;
    fin_d       = fin_q;
    chg_d       = chg_q;
    sym_d       = sym_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = cnt_q[StateW-1:0];
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    fset_d      = fset_q;

    tbl_ctrl             = '0;
    tbl_ctrl.trans_waddr = {symbol_i, state_index_i};
    tbl_ctrl.eps_waddr   = state_index_i;
    tbl_ctrl.wdata       = row_mask_i;
    tbl_ctrl.trans_raddr = {sym_q, cnt_q[StateW-1:0]};
    tbl_ctrl.eps_raddr   = cnt_q[StateW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_e'(req_type_i))
            REQ_TRANS: tbl_ctrl.trans_we = 1'b1;
            REQ_EPS:   tbl_ctrl.eps_we = 1'b1;
            REQ_SYMBOL: begin
              if (!invalid_q) begin
                if (!alpha_q[symbol_i]) begin
                  invalid_d = 1'b1;
                end else begin
                  sym_d   = symbol_i;
                  fin_d   = 1'b0;
                  cnt_d   = '0;
                  chg_d   = 1'b0;
                  state_d = ST_CLOSE;
                end
              end
            end
            REQ_FINISH: begin
              fin_d = 1'b1;
              cnt_d = '0;
              chg_d = 1'b0;
              state_d = invalid_q ? ST_EMIT : ST_CLOSE;
            end
            default: ;
          endcase
        end
      end
      ST_CLOSE: begin
        if (!cnt_q[CntW-1]) begin
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
        end
        // read data belongs to the row issued in the previous cycle
        if (rd_vld_q && active_q[rd_idx_q]) begin
          active_d = active_q | eps_rdata;
          if ((eps_rdata & ~active_q) != '0) begin
            chg_d = 1'b1;
          end
        end
        if (cnt_q[CntW-1] && !rd_vld_q) begin
          cnt_d = '0;
          chg_d = 1'b0;
          if (!chg_q) begin
            acc_d   = '0;
            state_d = fin_q ? ST_EMIT : ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (!cnt_q[CntW-1]) begin
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
        end
        if (rd_vld_q && active_q[rd_idx_q]) begin
          acc_d = acc_q | trans_rdata;
        end
        if (cnt_q[CntW-1] && !rd_vld_q) begin
          active_d = acc_q;
          state_d  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (invalid_q) begin
            verdict_d = VERDICT_INVALID;
            fset_d    = '0;
          end else begin
            verdict_d = ((active_q & final_q) != '0) ? VERDICT_ACCEPT : VERDICT_REJECT;
            fset_d    = active_q;
          end
          active_d  = SetW'(1) << start_q;
          invalid_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_acc) begin
      case (cfg_e'(cfg_index_i))
        CFG_START_STATE: begin
          start_d   = cfg_data_i[StateW-1:0];
          active_d  = SetW'(1) << cfg_data_i[StateW-1:0];
          invalid_d = 1'b0;
        end
        CFG_FINAL_MASK:    final_d = cfg_data_i;
        CFG_ALPHABET_MASK: alpha_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      final_q     <= '0;
      alpha_q     <= '1;
      active_q    <= SetW'(1);
      invalid_q   <= 1'b0;
      fin_q       <= 1'b0;
      chg_q       <= 1'b0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      final_q     <= final_d;
      alpha_q     <= alpha_d;
      active_q    <= active_d;
      invalid_q   <= invalid_d;
      fin_q       <= fin_d;
      chg_q       <= chg_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    sym_q     <= sym_d;
    rd_idx_q  <= rd_idx_d;
    verdict_q <= verdict_d;
    fset_q    <= fset_d;
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign final_set_o = fset_q;

endmodule

### hw/rtl/nfasim_tables.sv
// ----------------------------------------------------------------------------
// nfasim_tables
// Transition and epsilon row memories, registered read, with per-row valid
// bits so that rows never written read as empty.
// ----------------------------------------------------------------------------
module nfasim_tables (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  nfasim_pkg::tbl_ctrl_t    ctrl_i,
  output logic [nfasim_pkg::SetW-1:0] trans_rdata_o,
  output logic [nfasim_pkg::SetW-1:0] eps_rdata_o
);
  import nfasim_pkg::*;

  logic [SetW-1:0] trans_mem [TransDepth];
  logic [SetW-1:0] eps_mem   [NumStates];

  logic [TransDepth-1:0] trans_vld_q;
  logic [NumStates-1:0]  eps_vld_q;

  logic [SetW-1:0] trans_rd_q;
  logic [SetW-1:0] eps_rd_q;
  logic            trans_rd_vld_q;
  logic            eps_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.trans_we) begin
      trans_mem[ctrl_i.trans_waddr] <= ctrl_i.wdata;
    end
    if (ctrl_i.eps_we) begin
      eps_mem[ctrl_i.eps_waddr] <= ctrl_i.wdata;
    end
    trans_rd_q <= trans_mem[ctrl_i.trans_raddr];
    eps_rd_q   <= eps_mem[ctrl_i.eps_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_vld_q    <= '0;
      eps_vld_q      <= '0;
      trans_rd_vld_q <= 1'b0;
      eps_rd_vld_q   <= 1'b0;
    end else begin
      if (ctrl_i.trans_we) begin
        trans_vld_q[ctrl_i.trans_waddr] <= 1'b1;
      end
      if (ctrl_i.eps_we) begin
        eps_vld_q[ctrl_i.eps_waddr] <= 1'b1;
      end
      trans_rd_vld_q <= trans_vld_q[ctrl_i.trans_raddr];
      eps_rd_vld_q   <= eps_vld_q[ctrl_i.eps_raddr];
    end
  end

  assign trans_rdata_o = trans_rd_vld_q ? trans_rd_q : '0;
  assign eps_rdata_o   = eps_rd_vld_q ? eps_rd_q : '0;

endmodule

### hw/rtl/nfasim_checker.sv
// ----------------------------------------------------------------------------
// nfasim_checker
// Port-level checks of the epsilon-NFA simulator, bound to the top level.
// ----------------------------------------------------------------------------
module nfasim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  req_type_i,
  input logic [3:0]  symbol_i,
  input logic [3:0]  state_index_i,
  input logic [15:0] row_mask_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  verdict_o,
  input logic [15:0] final_set_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [15:0] cfg_data_i
);
  import nfasim_pkg::*;

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o) && $stable(final_set_o))
    else $error("stalled result changed");

  // an invalid word reports an empty set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_INVALID) |-> (final_set_o == '0))
    else $error("invalid verdict with nonempty set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o == VERDICT_REJECT) || (verdict_o == VERDICT_ACCEPT) ||
                    (verdict_o == VERDICT_INVALID))
    else $error("undefined verdict code");

  // a finish item always makes the block busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_FINISH) |=> in_stall_o)
    else $error("finish item did not start work");

  // a row write leaves the input unstalled in the cycle after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && ((req_type_i == REQ_TRANS) || (req_type_i == REQ_EPS))
    |=> !in_stall_o)
    else $error("row write stalled the input");

endmodule

bind nfa_epsilon_simulator nfasim_checker u_nfasim_checker (.*);
